### rtl/core/bads_pkg.sv
`default_nettype none

package bads_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int CFG_SIZE_W   = 11;
  localparam int CFG_FACTOR_W = 5;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;
  localparam int REG_IDX_W    = 2;

  localparam logic [CFG_SIZE_W-1:0]   RESET_IMAGE_WIDTH  = 11'd64;
  localparam logic [CFG_SIZE_W-1:0]   RESET_IMAGE_HEIGHT = 11'd64;
  localparam logic [CFG_FACTOR_W-1:0] RESET_FACTOR_X     = 5'd1;
  localparam logic [CFG_FACTOR_W-1:0] RESET_FACTOR_Y     = 5'd1;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FACTOR_X     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FACTOR_Y     = 2'd3;

  // divider operand select
  localparam logic [1:0] DSEL_LIMX = 2'd0;
  localparam logic [1:0] DSEL_LIMY = 2'd1;
  localparam logic [1:0] DSEL_AVG  = 2'd2;

  typedef struct packed {
    logic [CFG_SIZE_W-1:0]   image_width;
    logic [CFG_SIZE_W-1:0]   image_height;
    logic [CFG_FACTOR_W-1:0] factor_x;
    logic [CFG_FACTOR_W-1:0] factor_y;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       step;
    logic       absval;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_limx;
    logic       cap_limy;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/box_average_downsampler_top.sv
`default_nettype none

// A sample that ends no block passes through accept and update.
// A sample that ends a block goes on through magnitude, divider start, division
// by the one-bit-per-cycle divider and a stallable output load; one sample at a time.
// Reset (rst, synchronous) clears counters and output valid, loads register
// defaults, then recomputes block limits (tready low);
// the same recompute follows every register write.
module box_average_downsampler_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] average
  output logic        m_tlast,   // row_end
  output logic [0:0]  m_tuser,   // [0] slice_end
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bads_pkg::*;

  cfg_t    cfg;
  logic    cfg_write;
  cmd_t    cmd;
  status_t status;

  bads_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .cfg_write (cfg_write)
  );

  bads_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bads_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### rtl/core/bads_regs.sv
`default_nettype none

module bads_regs (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [bads_pkg::APB_ADDR_W-1:0] paddr,
  input  wire  [bads_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bads_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready,
  output bads_pkg::cfg_t                cfg,
  output logic                          cfg_write
);
  import bads_pkg::*;

  logic [REG_IDX_W-1:0] idx;

  assign idx       = paddr[REG_IDX_W+1:2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RESET_IMAGE_WIDTH;
      cfg.image_height <= RESET_IMAGE_HEIGHT;
      cfg.factor_x     <= RESET_FACTOR_X;
      cfg.factor_y     <= RESET_FACTOR_Y;
    end else if (cfg_write) begin
      case (idx)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[CFG_SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[CFG_SIZE_W-1:0];
        REG_FACTOR_X:     cfg.factor_x     <= pwdata[CFG_FACTOR_W-1:0];
        REG_FACTOR_Y:     cfg.factor_y     <= pwdata[CFG_FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(cfg.image_height);
      REG_FACTOR_X:     prdata = APB_DATA_W'(cfg.factor_x);
      REG_FACTOR_Y:     prdata = APB_DATA_W'(cfg.factor_y);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bads_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module bads_div #(
  parameter int N  = 40,
  parameter int DW = 9
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           start,
  input  wire  [N-1:0]  dividend,
  input  wire  [DW-1:0] divisor,
  output logic [N-1:0]  quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(N + 1);

  logic [DW-1:0]    dvs;
  logic [DW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  assign trial = {rem, quotient[N-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(N);
        quotient <= dividend;
        rem      <= '0;
        dvs      <= divisor;
      end else if (busy) begin
        rem      <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quotient <= {quotient[N-2:0], ge};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/bads_ctrl.sv
`default_nettype none

module bads_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_write,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  bads_pkg::status_t status,
  output bads_pkg::cmd_t    cmd
);
  import bads_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_LIMX      = 4'd1;
  localparam logic [3:0] S_LIMX_WAIT = 4'd2;
  localparam logic [3:0] S_LIMY      = 4'd3;
  localparam logic [3:0] S_LIMY_WAIT = 4'd4;
  localparam logic [3:0] S_STEP      = 4'd5;
  localparam logic [3:0] S_ABS       = 4'd6;
  localparam logic [3:0] S_DIV_GO    = 4'd7;
  localparam logic [3:0] S_DIV_WAIT  = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  // block limits must be recomputed before the next sample
  logic       dirty;

  assign s_tready = (state == S_IDLE) && !dirty;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DSEL_AVG;
    case (state)
      S_IDLE: begin
        if (dirty) begin
          state_next = S_LIMX;
        end else if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_STEP;
        end
      end
      S_LIMX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_LIMX;
        state_next    = S_LIMX_WAIT;
      end
      S_LIMX_WAIT: begin
        if (status.div_done) begin
          cmd.cap_limx = 1'b1;
          state_next   = S_LIMY;
        end
      end
      S_LIMY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_LIMY;
        state_next    = S_LIMY_WAIT;
      end
      S_LIMY_WAIT: begin
        if (status.div_done) begin
          cmd.cap_limy = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = status.emit ? S_ABS : S_IDLE;
      end
      S_ABS: begin
        cmd.absval = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dirty <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_write) dirty <= 1'b1;
      else if (state == S_LIMX) dirty <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bads_datapath.sv
`default_nettype none

module bads_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  wire                           clk,
  input  wire                           rst,
  input  bads_pkg::cfg_t                cfg,
  input  bads_pkg::cmd_t                cmd,
  output bads_pkg::status_t             status,
  input  wire  [bads_pkg::SAMPLE_W-1:0] s_tdata,
  input  wire                           m_tready,
  output logic                          m_tvalid,
  output logic [bads_pkg::SAMPLE_W-1:0] m_tdata,
  output logic                          m_tlast,
  output logic [0:0]                    m_tuser
);
  import bads_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int CW    = AW + 1;
  localparam int FB    = $clog2(MAX_FACTOR);
  localparam int FW    = FB + 1;
  localparam int SUM_W = SAMPLE_W + 2 * FB;
  localparam int DVW   = 2 * FB + 1;
  localparam int WEXT  = (CW > CFG_SIZE_W) ? CW : CFG_SIZE_W;
  localparam int FEXT  = (FW > CFG_FACTOR_W) ? FW : CFG_FACTOR_W;

  // effective sizes and factors
  logic [WEXT-1:0] w_ext, h_ext;
  logic [FEXT-1:0] fx_ext, fy_ext;
  logic [CW-1:0]   w, h;
  logic [FW-1:0]   fx, fy;
  logic [FB-1:0]   fx_m1, fy_m1;
  logic [2*FW-1:0] n_full;
  logic [DVW-1:0]  n;

  // limits from the divider: outputs per row, first dropped column/row
  logic [CW-1:0]    out_w, out_h, lim_x, lim_y;
  logic [CW+FW-1:0] lim_x_full, lim_y_full;

  // position counters
  logic [CW-1:0]    ic, ir, oc;
  logic [FB-1:0]    sc, sr;
  logic [SUM_W-1:0] rs;

  // wrapped copies used at accept
  logic             wrap_c, wrap_r;
  logic [CW-1:0]    ic_n, ir_n, oc_n;
  logic [FB-1:0]    sc_a, sr_a, sc_n, sr_n;
  logic [SUM_W-1:0] rs_n;
  logic [SUM_W-1:0] x;
  logic             in_n;

  // flags of the sample in flight
  logic f_in, f_col_last, f_row_nz, f_row_last, f_re, f_se;

  logic [SUM_W-1:0] col_mem [MAX_WIDTH];
  logic [SUM_W-1:0] rd;
  logic [SUM_W-1:0] total_c, total, mag;
  logic             neg;

  logic [CW-1:0]    ic_inc, ir_inc;
  logic [FW-1:0]    sr_inc;

  logic [SUM_W-1:0] div_a;
  logic [DVW-1:0]   div_b;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] quo_s;
  logic             div_done;

  assign w_ext  = WEXT'(cfg.image_width);
  assign h_ext  = WEXT'(cfg.image_height);
  assign fx_ext = FEXT'(cfg.factor_x);
  assign fy_ext = FEXT'(cfg.factor_y);

  always_comb begin
    if (w_ext == '0)                   w = CW'(1);
    else if (w_ext > WEXT'(MAX_WIDTH)) w = CW'(MAX_WIDTH);
    else                               w = w_ext[CW-1:0];
    if (h_ext == '0)                   h = CW'(1);
    else if (h_ext > WEXT'(MAX_WIDTH)) h = CW'(MAX_WIDTH);
    else                               h = h_ext[CW-1:0];
    if (fx_ext == '0)                    fx = FW'(1);
    else if (fx_ext > FEXT'(MAX_FACTOR)) fx = FW'(MAX_FACTOR);
    else                                 fx = fx_ext[FW-1:0];
    if (fy_ext == '0)                    fy = FW'(1);
    else if (fy_ext > FEXT'(MAX_FACTOR)) fy = FW'(MAX_FACTOR);
    else                                 fy = fy_ext[FW-1:0];
  end

  assign fx_m1  = FB'(fx - FW'(1));
  assign fy_m1  = FB'(fy - FW'(1));
  assign n_full = (2*FW)'(fx) * (2*FW)'(fy);
  assign n      = n_full[DVW-1:0];

  // a counter at or past its bound restarts before the sample is used
  always_comb begin
    wrap_c = ic >= w;
    wrap_r = ir >= h;
    ic_n   = wrap_c ? '0 : ic;
    oc_n   = wrap_c ? '0 : oc;
    sc_a   = wrap_c ? '0 : sc;
    rs_n   = wrap_c ? '0 : rs;
    ir_n   = wrap_r ? '0 : ir;
    sr_a   = wrap_r ? '0 : sr;
    sc_n   = (FW'(sc_a) >= fx) ? '0 : sc_a;
    sr_n   = (FW'(sr_a) >= fy) ? '0 : sr_a;
    in_n   = (ic_n < lim_x) && (ir_n < lim_y);
  end

  assign x       = {{(SUM_W-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
  assign total_c = rs + (f_row_nz ? rd : '0);
  assign ic_inc  = ic + CW'(1);
  assign ir_inc  = ir + CW'(1);
  assign sr_inc  = FW'(sr) + FW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ic <= '0;
      ir <= '0;
      oc <= '0;
      sc <= '0;
      sr <= '0;
      rs <= '0;
    end else if (cmd.accept) begin
      ic <= ic_n;
      ir <= ir_n;
      oc <= oc_n;
      sc <= sc_n;
      sr <= sr_n;
      rs <= in_n ? rs_n + x : rs_n;
    end else if (cmd.step) begin
      if (f_in && f_col_last) begin
        rs <= '0;
        oc <= oc + CW'(1);
        sc <= '0;
      end else if (f_in) begin
        sc <= sc + FB'(1);
      end
      // end of input row
      if (ic_inc >= w) begin
        ic <= '0;
        oc <= '0;
        sc <= '0;
        rs <= '0;
        if (ir < lim_y) sr <= (sr_inc >= fy) ? '0 : sr_inc[FB-1:0];
        if (ir_inc >= h) begin
          ir <= '0;
          sr <= '0;
        end else begin
          ir <= ir_inc;
        end
      end else begin
        ic <= ic_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      f_in       <= in_n;
      f_col_last <= sc_n == fx_m1;
      f_row_nz   <= sr_n != '0;
      f_row_last <= sr_n == fy_m1;
      f_re       <= oc_n == out_w - CW'(1);
      f_se       <= (oc_n == out_w - CW'(1)) && (ir_n >= lim_y - CW'(fy));
    end
    if (cmd.step) total <= total_c;
    if (cmd.absval) begin
      neg <= total[SUM_W-1];
      mag <= total[SUM_W-1] ? (~total + SUM_W'(1)) : total;
    end
  end

  // line store of partial block sums
  always_ff @(posedge clk) begin
    if (cmd.accept) rd <= col_mem[oc_n[AW-1:0]];
    if (cmd.step && f_in && f_col_last && !f_row_last) col_mem[oc[AW-1:0]] <= total_c;
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_LIMX: begin
        div_a = SUM_W'(w);
        div_b = DVW'(fx);
      end
      DSEL_LIMY: begin
        div_a = SUM_W'(h);
        div_b = DVW'(fy);
      end
      default: begin
        // round half away from zero on the magnitude
        div_a = mag + SUM_W'(n >> 1);
        div_b = n;
      end
    endcase
  end

  bads_div #(
    .N  (SUM_W),
    .DW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quo),
    .done     (div_done)
  );

  assign lim_x_full = (CW+FW)'(quo[CW-1:0]) * (CW+FW)'(fx);
  assign lim_y_full = (CW+FW)'(quo[CW-1:0]) * (CW+FW)'(fy);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_w <= '0;
      out_h <= '0;
      lim_x <= '0;
      lim_y <= '0;
    end else begin
      if (cmd.cap_limx) begin
        out_w <= quo[CW-1:0];
        lim_x <= lim_x_full[CW-1:0];
      end
      if (cmd.cap_limy) begin
        out_h <= quo[CW-1:0];
        lim_y <= lim_y_full[CW-1:0];
      end
    end
  end

  assign quo_s = neg ? (~quo + SUM_W'(1)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata    <= quo_s[SAMPLE_W-1:0];
      m_tlast    <= f_re;
      m_tuser[0] <= f_se;
    end
  end

  // out_h gates emit when there is no output row; lim_y carries the same information
  assign status.emit     = f_in && f_col_last && f_row_last && (out_h != '0);
  assign status.div_done = div_done;
  assign status.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

### rtl/core/bads_checker.sv
`default_nettype none

module bads_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [31:0] m_tdata,
  input wire        m_tlast,
  input wire [0:0]  m_tuser,
  input wire        psel,
  input wire        penable,
  input wire        pwrite
);

  // output valid is cleared by reset
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // a slice end is always also a row end
  a_slice_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[0] || m_tlast))
    else $error("slice_end without row_end");

  // one sample in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  // a register write stops input until limits are rebuilt
  a_cfg_block: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> !s_tready)
    else $error("input ready right after register write");

endmodule

bind box_average_downsampler_top bads_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite)
);

`default_nettype wire

### dv/box_average_downsampler_top_tb.sv
`timescale 1ns / 100ps

module box_average_downsampler_top_tb;
  import bads_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int MAX_F       = 16;
  localparam int SETTLE      = 100;   // margin over the worst block latency
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                row_end;
    logic                slice_end;
  } mean_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [31:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tlast;
  logic [0:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  box_average_downsampler_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [CFG_SIZE_W-1:0]   geo_width  = RESET_IMAGE_WIDTH;
  logic [CFG_SIZE_W-1:0]   geo_height = RESET_IMAGE_HEIGHT;
  logic [CFG_FACTOR_W-1:0] geo_fx     = RESET_FACTOR_X;
  logic [CFG_FACTOR_W-1:0] geo_fy     = RESET_FACTOR_Y;
  longint      col_sum [MAX_W];
  longint      row_acc = 0;
  int unsigned in_col = 0, in_row = 0, out_col = 0, sub_col = 0, sub_row = 0;

  mean_beat_t mean_q[$];
  mean_beat_t oldest;
  int mismatches = 0;
  int n_samples = 0;
  int n_means = 0;
  int n_geoms = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int stuck = 0;

  // output hold-off request, counted down by the receiver
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  int hold_len = 0;
  int hold_cnt = 0;

  function automatic int unsigned clamp_geom(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit predict_block_mean(input logic [SAMPLE_W-1:0] smp,
                                            output mean_beat_t res);
    int unsigned w, h, fx, fy, out_w, out_h, oc, n;
    longint x, total, avg;
    longint unsigned mag, q;
    bit hit;
    w = clamp_geom(geo_width, MAX_W);
    h = clamp_geom(geo_height, MAX_W);
    fx = clamp_geom(geo_fx, MAX_F);
    fy = clamp_geom(geo_fy, MAX_F);
    out_w = w / fx;
    out_h = h / fy;
    n = fx * fy;
    x = $signed(smp);
    hit = 1'b0;
    res = '0;
    if (in_col >= w) begin
      in_col = 0;
      out_col = 0;
      sub_col = 0;
      row_acc = 0;
    end
    if (in_row >= h) begin
      in_row = 0;
      sub_row = 0;
    end
    if (sub_col >= fx) sub_col = 0;
    if (sub_row >= fy) sub_row = 0;
    if (in_col < out_w * fx && in_row < out_h * fy) begin
      row_acc += x;
      if (sub_col == fx - 1) begin
        oc = out_col % MAX_W;
        total = row_acc;
        if (sub_row != 0) total += col_sum[oc];
        if (sub_row == fy - 1) begin
          // round half away from zero on the magnitude
          mag = (total < 0) ? -total : total;
          q = (mag + n / 2) / n;
          avg = (total < 0) ? -longint'(q) : longint'(q);
          res.average = avg[31:0];
          res.row_end = (out_col == out_w - 1);
          res.slice_end = res.row_end && (in_row / fy == out_h - 1);
          hit = 1'b1;
        end else begin
          col_sum[oc] = total;
        end
        row_acc = 0;
        out_col++;
        sub_col = 0;
      end else begin
        sub_col++;
      end
    end
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      out_col = 0;
      sub_col = 0;
      row_acc = 0;
      if (in_row < out_h * fy) sub_row = (sub_row + 1 >= fy) ? 0 : sub_row + 1;
      in_row++;
      if (in_row >= h) begin
        in_row = 0;
        sub_row = 0;
      end
    end
    return hit;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return 32'($urandom_range(1023)) - 32'd512;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(15)
                                  : 32'h8000_0000 + $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt <= hold_len;
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_means++;
      if (mean_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, got avg=%h row_end=%b slice_end=%b",
                 $time, m_tdata, m_tlast, m_tuser[0]);
      end else begin
        oldest = mean_q.pop_front();
        if (m_tdata !== oldest.average) begin
          mismatches++;
          $display("%0t: average expected %h got %h", $time, oldest.average, m_tdata);
        end
        if (m_tlast !== oldest.row_end) begin
          mismatches++;
          $display("%0t: row_end expected %b got %b", $time, oldest.row_end, m_tlast);
        end
        if (m_tuser[0] !== oldest.slice_end) begin
          mismatches++;
          $display("%0t: slice_end expected %b got %b", $time, oldest.slice_end, m_tuser[0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d means still due",
               $time, STUCK_LIMIT, mean_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // all tasks are entered and left just after a falling edge
  task automatic push_sample(input logic [31:0] smp);
    mean_beat_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_samples++;
    if (predict_block_mean(smp, res)) mean_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_slice(input int count);
    repeat (count) push_sample(rand_sample());
  endtask

  task automatic drain_and_settle();
    s_tvalid = 1'b0;
    while (mean_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val,
                           input int field_w);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = 32'(val);
    // junk above the field must be ignored
    if ($urandom_range(3) == 0) pwdata = pwdata | ($urandom << field_w);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  geo_width = pwdata[CFG_SIZE_W-1:0];
      REG_IMAGE_HEIGHT: geo_height = pwdata[CFG_SIZE_W-1:0];
      REG_FACTOR_X:     geo_fx = pwdata[CFG_FACTOR_W-1:0];
      REG_FACTOR_Y:     geo_fy = pwdata[CFG_FACTOR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h, input int fx, input int fy);
    drain_and_settle();
    write_reg(REG_IMAGE_WIDTH, w, CFG_SIZE_W);
    write_reg(REG_IMAGE_HEIGHT, h, CFG_SIZE_W);
    write_reg(REG_FACTOR_X, fx, CFG_FACTOR_W);
    write_reg(REG_FACTOR_Y, fy, CFG_FACTOR_W);
    n_geoms++;
  endtask

  // full-scale inputs and round-half-away-from-zero; factor_y of 0 acts as 1
  task automatic test_rounding();
    set_geometry(2, 1, 2, 0);
    push_sample(32'h7FFF_FFFF); push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000); push_sample(32'h8000_0000);
    push_sample(32'h0000_0001); push_sample(32'h0000_0000);
    push_sample(32'hFFFF_FFFF); push_sample(32'h0000_0000);
    push_sample(32'h7FFF_FFFF); push_sample(32'h8000_0000);
    push_sample(32'h0000_0003); push_sample(32'h0000_0000);
  endtask

  // last column and last row do not fill a block and are dropped
  task automatic test_leftover();
    set_geometry(3, 3, 2, 2);
    send_slice(9);
  endtask

  task automatic test_factor_over_size();
    set_geometry(2, 1, 3, 1);
    send_slice(2);
  endtask

  task automatic test_zero_width();
    set_geometry(0, 2, 1, 2);
    send_slice(2);
  endtask

  // oversized registers saturate; deepest block sum
  task automatic test_max_geometry();
    set_geometry(1500, 1, 31, 1);
    send_slice(64);
    set_geometry(1, 2047, 0, 31);
    send_slice(32);
    set_geometry(16, 16, 16, 16);
    repeat (256) push_sample(32'h8000_0000);
  endtask

  task automatic test_output_hold();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    set_geometry(8, 8, 1, 1);
    @(posedge clk);
    hold_len = HOLD_CYCLES;
    hold_go = ~hold_go;
    @(negedge clk);
    send_slice(64);
  endtask

  task automatic test_random_geometry(input int src_pct, input int snk_pct,
                                      input int quota);
    int start, w, h, fx, fy;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    start = n_samples;
    while (n_samples - start < quota) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 10);
      fx = $urandom_range(1, (w < MAX_F) ? w : MAX_F);
      fy = $urandom_range(1, (h < MAX_F) ? h : MAX_F);
      if ($urandom_range(7) == 0) fx = $urandom_range(0, 31);
      if ($urandom_range(7) == 0) fy = $urandom_range(0, 31);
      set_geometry(w, h, fx, fy);
      repeat ($urandom_range(1, 2)) send_slice(w * h);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_rounding();
    test_leftover();
    test_factor_over_size();
    test_zero_width();
    test_max_geometry();
    test_output_hold();
    test_random_geometry(0, 0, 60);
    test_random_geometry(76, 0, 60);
    test_random_geometry(0, 76, 60);
    test_random_geometry(8, 8, 60);
    drain_and_settle();
    $display("Run sent %0d samples and checked %0d block means over %0d geometries,",
             n_samples, n_means, n_geoms);
    $display("with sender gaps, output stalls and a %0d-cycle output hold.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
